// File: design/mdel_pkg.sv
// ----------------------------------------------------------------------------
// mdel_pkg: shared types and constants
// Transaction payload structs, a pin polarity mask, reset values and edge codes
// for the multi-input debounce and edge latch block.
// ----------------------------------------------------------------------------
package mdel_pkg;

    // Field widths.
    localparam int PIN_W   = 8;
    localparam int DIP_W   = 6;
    localparam int CLR_W   = 4;
    localparam int EDGE_W  = 2;
    localparam int LED_W   = 6;
    localparam int TRACK_N = 4;
    localparam int LIMIT_W = 8;

    // Raw pins b0..b4 are active low, b5..b7 active high.
    localparam logic [PIN_W-1:0] ACTIVE_LOW_MASK = 8'h1F;

    // Level registers of up, down and switch3 start high, sen2 starts low.
    localparam logic [TRACK_N-1:0] PIN_LEVEL_RESET = 4'h7;

    // Prescaler defaults.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;
    localparam logic [LIMIT_W-1:0] TICK_MAX    = 8'hFF;

    // Sticky edge codes.
    localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_FALL = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_RISE = 2'd2;

    // Raw pin positions.
    localparam int PIN_UP      = 0;
    localparam int PIN_DOWN    = 1;
    localparam int PIN_SWITCH3 = 3;
    localparam int PIN_SEN1    = 4;
    localparam int PIN_SEN2    = 5;
    localparam int PIN_LIM_UP  = 6;
    localparam int PIN_LIM_DN  = 7;

    typedef struct packed {
        logic [PIN_W-1:0] raw_pins;
        logic [DIP_W-1:0] raw_dip_pins;
        logic [CLR_W-1:0] clear_edges;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0]  stable_inputs;
        logic [DIP_W-1:0]  stable_dip;
        logic [EDGE_W-1:0] up_edge;
        logic [EDGE_W-1:0] down_edge;
        logic [EDGE_W-1:0] switch3_edge;
        logic [EDGE_W-1:0] sen2_edge;
        logic [LED_W-1:0]  led_drive;
    } out_item_t;

endpackage

// File: design/mdel_debounce.sv
// ----------------------------------------------------------------------------
// mdel_debounce: sample history and agreement filter
// Keeps the previous samples of a bus and takes over a new sample as the
// stable value only when it matches every stored sample.
// ----------------------------------------------------------------------------
module mdel_debounce #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             sample_en,
    input  logic [WIDTH-1:0] sample_value,
    output logic [WIDTH-1:0] stable_next
);

    logic [WIDTH-1:0] hist_reg [DEPTH];
    logic [WIDTH-1:0] stable_reg;
    logic             agree;

    // The new sample agrees when all stored samples equal it.
    always_comb begin
        agree = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            if (hist_reg[i] != sample_value) begin
                agree = 1'b0;
            end
        end
    end

    // Next stable value, visible in the same cycle for the result register.
    assign stable_next = (sample_en && agree) ? sample_value : stable_reg;

    // History shift and stable register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            stable_reg <= '0;
        end else if (sample_en) begin
            hist_reg[0] <= sample_value;
            for (int i = 1; i < DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            stable_reg <= stable_next;
        end
    end

endmodule

// File: design/multi_input_debounce_edge_latch.sv
// ----------------------------------------------------------------------------
// multi_input_debounce_edge_latch: pin debounce with sticky edge flags
// A prescaler picks one tick in every limit+2 as a sample, or one in every
// limit+1 when the limit is 255. Samples are polarity corrected and debounced,
// four pins latch edge codes and six LED mirror bits follow the raw sample.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_data  (mdel_pkg::in_item_t)
// m_        out        m_valid / m_ready      m_data  (mdel_pkg::out_item_t)
// cfg_      in         cfg_valid / cfg_ready  cfg_data (sample_prescale_limit)
//
// Each accepted transaction is one tick and yields one result transaction in the
// next cycle; a new transaction can be taken every cycle unless m_ready stalls it.
// The result register decouples the sides: input is taken whenever the result
// register is empty or being drained in the same cycle.
// Reset is synchronous and active low; no clearing pass is needed.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module multi_input_debounce_edge_latch #(
    parameter int AGREE_SAMPLES = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mdel_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mdel_pkg::out_item_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [mdel_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int HIST_DEPTH = AGREE_SAMPLES - 1;

    logic [mdel_pkg::LIMIT_W-1:0] limit_reg;
    logic [mdel_pkg::LIMIT_W-1:0] tick_count_reg;
    logic [mdel_pkg::LIMIT_W-1:0] tick_count_next;
    logic [mdel_pkg::TRACK_N-1:0] pin_levels_reg;
    logic [mdel_pkg::TRACK_N-1:0] pin_levels_next;
    logic [mdel_pkg::EDGE_W-1:0]  edge_reg  [mdel_pkg::TRACK_N];
    logic [mdel_pkg::EDGE_W-1:0]  edge_next [mdel_pkg::TRACK_N];
    logic [mdel_pkg::LED_W-1:0]   led_reg;
    logic [mdel_pkg::LED_W-1:0]   led_next;
    logic                         m_valid_reg;
    mdel_pkg::out_item_t          m_data_reg;
    mdel_pkg::out_item_t          m_data_next;

    logic                         s_accept;
    logic                         sample;
    logic                         step_sample;
    logic [mdel_pkg::PIN_W-1:0]   act_pins;
    logic [mdel_pkg::DIP_W-1:0]   act_dip;
    logic [mdel_pkg::TRACK_N-1:0] track_pins;
    logic [mdel_pkg::PIN_W-1:0]   stable_pins_next;
    logic [mdel_pkg::DIP_W-1:0]   stable_dip_next;

    // Handshakes.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Prescaler: sample when the count passes the limit or hits its top.
    assign sample          = (tick_count_reg > limit_reg) ||
                             (tick_count_reg == mdel_pkg::TICK_MAX);
    assign step_sample     = s_accept && sample;
    assign tick_count_next = sample ? '0 : tick_count_reg + 1'b1;

    // Polarity correction of the raw sample, and the raw levels of the tracked pins.
    assign act_pins   = s_data.raw_pins ^ mdel_pkg::ACTIVE_LOW_MASK;
    assign act_dip    = ~s_data.raw_dip_pins;
    assign track_pins = {s_data.raw_pins[mdel_pkg::PIN_SEN2],
                         s_data.raw_pins[mdel_pkg::PIN_SWITCH3],
                         s_data.raw_pins[mdel_pkg::PIN_DOWN],
                         s_data.raw_pins[mdel_pkg::PIN_UP]};

    // Debounce filters for the pin bus and the DIP bus.
    mdel_debounce #(
        .WIDTH (mdel_pkg::PIN_W),
        .DEPTH (HIST_DEPTH)
    ) u_pin_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_en    (step_sample),
        .sample_value (act_pins),
        .stable_next  (stable_pins_next)
    );

    mdel_debounce #(
        .WIDTH (mdel_pkg::DIP_W),
        .DEPTH (HIST_DEPTH)
    ) u_dip_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_en    (step_sample),
        .sample_value (act_dip),
        .stable_next  (stable_dip_next)
    );

    // Edge codes: clears first, then a fresh edge on this sample wins.
    always_comb begin
        pin_levels_next = pin_levels_reg;
        for (int i = 0; i < mdel_pkg::TRACK_N; i++) begin
            edge_next[i] = s_data.clear_edges[i] ? mdel_pkg::EDGE_NONE : edge_reg[i];
            if (sample) begin
                if (!track_pins[i] && pin_levels_reg[i]) begin
                    edge_next[i] = mdel_pkg::EDGE_FALL;
                end else if (track_pins[i] && !pin_levels_reg[i]) begin
                    edge_next[i] = mdel_pkg::EDGE_RISE;
                end
                pin_levels_next[i] = track_pins[i];
            end
        end
    end

    // LED mirror bits follow the raw sample; sen1 polarity set by DIP bit 0.
    always_comb begin
        led_next = led_reg;
        if (sample) begin
            led_next = {s_data.raw_pins[mdel_pkg::PIN_LIM_DN],
                        s_data.raw_pins[mdel_pkg::PIN_LIM_UP],
                        s_data.raw_pins[mdel_pkg::PIN_SEN2],
                        s_data.raw_pins[mdel_pkg::PIN_SEN1] ^ s_data.raw_dip_pins[0],
                        ~s_data.raw_pins[mdel_pkg::PIN_DOWN],
                        ~s_data.raw_pins[mdel_pkg::PIN_UP]};
        end
    end

    // Result assembled from the state after this tick.
    always_comb begin
        m_data_next.stable_inputs = stable_pins_next;
        m_data_next.stable_dip    = stable_dip_next;
        m_data_next.up_edge       = edge_next[0];
        m_data_next.down_edge     = edge_next[1];
        m_data_next.switch3_edge  = edge_next[2];
        m_data_next.sen2_edge     = edge_next[3];
        m_data_next.led_drive     = led_next;
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= mdel_pkg::LIMIT_RESET;
            tick_count_reg <= '0;
            pin_levels_reg <= mdel_pkg::PIN_LEVEL_RESET;
            led_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < mdel_pkg::TRACK_N; i++) begin
                edge_reg[i] <= mdel_pkg::EDGE_NONE;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (s_accept) begin
                tick_count_reg <= tick_count_next;
                pin_levels_reg <= pin_levels_next;
                led_reg        <= led_next;
                for (int i = 0; i < mdel_pkg::TRACK_N; i++) begin
                    edge_reg[i] <= edge_next[i];
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
